[hdl/tlfk_pkg.sv]
package tlfk_pkg;

    localparam int FIELD_W     = 16;
    localparam int LEN_W       = 15;
    localparam int ANGLE_W     = 13;
    localparam int PHASE_W     = 11;
    localparam int CFG_INDEX_W = 2;

    localparam int QUARTER_TURN = 1440;
    localparam int FULL_TURN    = 5760;

    // Angle reduction: bias by six turns, then (u >> 7) mod 45 by reciprocal.
    localparam int ANGLE_BIAS      = 34560;
    localparam int MOD_LOW_BITS    = 7;
    localparam int MOD_HIGH_W      = 10;
    localparam int MOD_ODD         = 45;
    localparam int MOD_RECIP       = 1457;
    localparam int MOD_RECIP_SHIFT = 16;
    localparam int MOD_QUO_W       = 4;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int LANE_SIN1 = 0;
    localparam int LANE_COS1 = 1;
    localparam int LANE_SIN2 = 2;
    localparam int LANE_COS2 = 3;
    localparam int LANES     = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_X     = 2'd0,
        CFG_BASE_Y     = 2'd1,
        CFG_FIRST_LEN  = 2'd2,
        CFG_SECOND_LEN = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic               neg;
        logic [PHASE_W-1:0] phase;
    } t_trig_req;

endpackage

[hdl/tlfk_sine_rom.sv]
module tlfk_sine_rom #(
    parameter int TRIG_FRACTION_BITS = 15,
    parameter int SINE_TABLE_DEPTH   = 1440
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [tlfk_pkg::PHASE_W-1:0]        i_addr_a,
    input  logic [tlfk_pkg::PHASE_W-1:0]        i_addr_b,
    output logic [TRIG_FRACTION_BITS:0]         o_data_a,
    output logic [TRIG_FRACTION_BITS:0]         o_data_b
);

    localparam int MAG_W    = TRIG_FRACTION_BITS + 1;
    localparam int ROM_COLS = 32;
    localparam int ROM_ROWS = tlfk_pkg::QUARTER_TURN / ROM_COLS + 1;

    typedef logic [MAG_W-1:0] t_rom [tlfk_pkg::QUARTER_TURN+1];

    // Quarter-wave sine magnitude, Horner Taylor series through x^13 in Q30.
    function automatic t_rom build_rom();
        t_rom              tab;
        int                p;
        longint unsigned   k;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   r;
        longint unsigned   sub;
        for (int hi = 0; hi < ROM_ROWS; hi++) begin
            for (int lo = 0; lo < ROM_COLS; lo++) begin
                p = hi * ROM_COLS + lo;
                if (p <= tlfk_pkg::QUARTER_TURN) begin
                    k  = (64'(p) * 64'(SINE_TABLE_DEPTH)) / 64'(tlfk_pkg::QUARTER_TURN);
                    x  = (k * tlfk_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
                    x2 = (x * x) >> 30;
                    t  = tlfk_pkg::Q30_ONE;
                    sub = ((x2 * t) >> 30) / 64'd156;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    sub = ((x2 * t) >> 30) / 64'd110;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    sub = ((x2 * t) >> 30) / 64'd72;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    sub = ((x2 * t) >> 30) / 64'd42;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    sub = ((x2 * t) >> 30) / 64'd20;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    sub = ((x2 * t) >> 30) / 64'd6;
                    t   = (sub > tlfk_pkg::Q30_ONE) ? 64'd0 : tlfk_pkg::Q30_ONE - sub;
                    s = (x * t) >> 30;
                    r = (s + (64'd1 << (29 - TRIG_FRACTION_BITS)))
                        >> (30 - TRIG_FRACTION_BITS);
                    if (r > (64'd1 << TRIG_FRACTION_BITS)) begin
                        r = 64'd1 << TRIG_FRACTION_BITS;
                    end
                    tab[p] = r[MAG_W-1:0];
                end
            end
        end
        return tab;
    endfunction

    localparam t_rom ROM_DATA = build_rom();

    logic [MAG_W-1:0] r_data_a;
    logic [MAG_W-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= ROM_DATA[i_addr_a];
            r_data_b <= ROM_DATA[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

[hdl/two_link_forward_kinematics_top.sv]
// Planar two-link arm, forward kinematics.
// Input channel: i_in_valid / o_in_stall with i_first_angle, i_second_angle
// (1/16 degree, any 16-bit pattern, reduced modulo 360 degrees).
// Output channel: o_out_valid / i_out_stall with elbow and tip coordinates in
// Q12.4, clipped to 16 bits, and o_saturated when any coordinate was clipped.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
// base_x, base_y, first_link_length, second_link_length; write only when idle.
// Stages, in order: reduce, quadrant and phase, quarter-wave ROM read, length
// multiply, sum and clip, ending at o_out_valid. One word per cycle is sustained
// while the receiver does not stall; the ROM has one copy per joint with two read ports
// (sine and cosine), and the multiply stage is one 15 x (F+1) product per lane.
// Reset clears all stage valid bits and sets the config registers to zero.
// When the receiver stalls, the output word holds and stall moves back one
// stage at a time; empty stages still fill, so o_in_stall rises only once all
// five stages hold words.
module two_link_forward_kinematics_top #(
    parameter int TRIG_FRACTION_BITS = 15,
    parameter int SINE_TABLE_DEPTH   = 1440
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [tlfk_pkg::FIELD_W-1:0]      i_first_angle,
    input  logic signed [tlfk_pkg::FIELD_W-1:0]      i_second_angle,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [tlfk_pkg::FIELD_W-1:0]      o_elbow_x,
    output logic signed [tlfk_pkg::FIELD_W-1:0]      o_elbow_y,
    output logic signed [tlfk_pkg::FIELD_W-1:0]      o_tip_x,
    output logic signed [tlfk_pkg::FIELD_W-1:0]      o_tip_y,
    output logic                                     o_saturated,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [tlfk_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [tlfk_pkg::FIELD_W-1:0]             i_cfg_data
);

    localparam int MAG_W  = TRIG_FRACTION_BITS + 1;
    localparam int PROD_W = tlfk_pkg::LEN_W + MAG_W;
    localparam int OFF_W  = tlfk_pkg::FIELD_W + 1;
    localparam int SUM_W  = tlfk_pkg::FIELD_W + 4;
    localparam int AW     = tlfk_pkg::ANGLE_W;

    // ---------------- helpers ----------------
    function automatic logic [AW-1:0] reduce_angle(input logic [tlfk_pkg::FIELD_W-1:0] raw);
        logic [tlfk_pkg::FIELD_W:0]             u;
        logic [tlfk_pkg::MOD_HIGH_W-1:0]        hi;
        logic [2*tlfk_pkg::MOD_HIGH_W:0]        prod;
        logic [tlfk_pkg::MOD_QUO_W-1:0]         quo;
        logic [tlfk_pkg::MOD_HIGH_W-1:0]        rem;
        u    = {raw[tlfk_pkg::FIELD_W-1], raw} + (tlfk_pkg::FIELD_W+1)'(tlfk_pkg::ANGLE_BIAS);
        hi   = u[tlfk_pkg::FIELD_W:tlfk_pkg::MOD_LOW_BITS];
        prod = (2*tlfk_pkg::MOD_HIGH_W+1)'(hi)
             * (2*tlfk_pkg::MOD_HIGH_W+1)'(tlfk_pkg::MOD_RECIP);
        quo  = tlfk_pkg::MOD_QUO_W'(prod >> tlfk_pkg::MOD_RECIP_SHIFT);
        rem  = hi - tlfk_pkg::MOD_HIGH_W'(quo) * tlfk_pkg::MOD_HIGH_W'(tlfk_pkg::MOD_ODD);
        return {rem[AW-tlfk_pkg::MOD_LOW_BITS-1:0], u[tlfk_pkg::MOD_LOW_BITS-1:0]};
    endfunction

    function automatic logic [AW-1:0] cos_angle(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(tlfk_pkg::QUARTER_TURN);
        if (s >= (AW+1)'(tlfk_pkg::FULL_TURN)) begin
            s = s - (AW+1)'(tlfk_pkg::FULL_TURN);
        end
        return s[AW-1:0];
    endfunction

    function automatic tlfk_pkg::t_trig_req phase_of(input logic [AW-1:0] a);
        tlfk_pkg::t_trig_req req;
        logic [AW-1:0]       ph;
        logic [1:0]          quad;
        if (a >= AW'(3 * tlfk_pkg::QUARTER_TURN)) begin
            quad = 2'd3;
            ph   = a - AW'(3 * tlfk_pkg::QUARTER_TURN);
        end else if (a >= AW'(2 * tlfk_pkg::QUARTER_TURN)) begin
            quad = 2'd2;
            ph   = a - AW'(2 * tlfk_pkg::QUARTER_TURN);
        end else if (a >= AW'(tlfk_pkg::QUARTER_TURN)) begin
            quad = 2'd1;
            ph   = a - AW'(tlfk_pkg::QUARTER_TURN);
        end else begin
            quad = 2'd0;
            ph   = a;
        end
        req.neg   = quad[1];
        req.phase = quad[0] ? tlfk_pkg::PHASE_W'(AW'(tlfk_pkg::QUARTER_TURN) - ph)
                            : tlfk_pkg::PHASE_W'(ph);
        return req;
    endfunction

    function automatic logic [tlfk_pkg::FIELD_W-1:0] clip16(input logic signed [SUM_W-1:0] v);
        logic ok;
        ok = (&v[SUM_W-1:tlfk_pkg::FIELD_W-1]) || !(|v[SUM_W-1:tlfk_pkg::FIELD_W-1]);
        if (ok) begin
            return v[tlfk_pkg::FIELD_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(tlfk_pkg::FIELD_W-1){1'b0}}}
                          : {1'b0, {(tlfk_pkg::FIELD_W-1){1'b1}}};
    endfunction

    function automatic logic out_of_range(input logic signed [SUM_W-1:0] v);
        return !((&v[SUM_W-1:tlfk_pkg::FIELD_W-1]) || !(|v[SUM_W-1:tlfk_pkg::FIELD_W-1]));
    endfunction

    // ---------------- config ----------------
    logic signed [tlfk_pkg::FIELD_W-1:0] r_base_x;
    logic signed [tlfk_pkg::FIELD_W-1:0] r_base_y;
    logic [tlfk_pkg::LEN_W-1:0]          r_first_len;
    logic [tlfk_pkg::LEN_W-1:0]          r_second_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x     <= '0;
            r_base_y     <= '0;
            r_first_len  <= '0;
            r_second_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tlfk_pkg::t_cfg_reg'(i_cfg_index))
                tlfk_pkg::CFG_BASE_X:     r_base_x     <= i_cfg_data;
                tlfk_pkg::CFG_BASE_Y:     r_base_y     <= i_cfg_data;
                tlfk_pkg::CFG_FIRST_LEN:  r_first_len  <= i_cfg_data[tlfk_pkg::LEN_W-1:0];
                tlfk_pkg::CFG_SECOND_LEN: r_second_len <= i_cfg_data[tlfk_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r1_v, r2_v, r3_v, r4_v, r_out_v;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5      = !r_out_v || !i_out_stall;
    assign w_en4      = !r4_v || w_en5;
    assign w_en3      = !r3_v || w_en4;
    assign w_en2      = !r2_v || w_en3;
    assign w_en1      = !r1_v || w_en2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_in_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
            if (w_en3) begin
                r3_v <= r2_v;
            end
            if (w_en4) begin
                r4_v <= r3_v;
            end
            if (w_en5) begin
                r_out_v <= r4_v;
            end
        end
    end

    // ---------------- stage 1: reduce ----------------
    logic [AW-1:0] r1_a1;
    logic [AW-1:0] r1_a2;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_a1 <= reduce_angle(i_first_angle);
            r1_a2 <= reduce_angle(i_second_angle);
        end
    end

    // ---------------- stage 2: quadrant and phase ----------------
    tlfk_pkg::t_trig_req r2_req [tlfk_pkg::LANES];

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_req[tlfk_pkg::LANE_SIN1] <= phase_of(r1_a1);
            r2_req[tlfk_pkg::LANE_COS1] <= phase_of(cos_angle(r1_a1));
            r2_req[tlfk_pkg::LANE_SIN2] <= phase_of(r1_a2);
            r2_req[tlfk_pkg::LANE_COS2] <= phase_of(cos_angle(r1_a2));
        end
    end

    // ---------------- stage 3: table read ----------------
    logic [MAG_W-1:0] w_mag [tlfk_pkg::LANES];
    logic             r3_neg [tlfk_pkg::LANES];

    tlfk_sine_rom #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS),
        .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH)
    ) u_rom_first (
        .i_clk    (i_clk),
        .i_en     (w_en3),
        .i_addr_a (r2_req[tlfk_pkg::LANE_SIN1].phase),
        .i_addr_b (r2_req[tlfk_pkg::LANE_COS1].phase),
        .o_data_a (w_mag[tlfk_pkg::LANE_SIN1]),
        .o_data_b (w_mag[tlfk_pkg::LANE_COS1])
    );

    tlfk_sine_rom #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS),
        .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH)
    ) u_rom_second (
        .i_clk    (i_clk),
        .i_en     (w_en3),
        .i_addr_a (r2_req[tlfk_pkg::LANE_SIN2].phase),
        .i_addr_b (r2_req[tlfk_pkg::LANE_COS2].phase),
        .o_data_a (w_mag[tlfk_pkg::LANE_SIN2]),
        .o_data_b (w_mag[tlfk_pkg::LANE_COS2])
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            for (int i = 0; i < tlfk_pkg::LANES; i++) begin
                r3_neg[i] <= r2_req[i].neg;
            end
        end
    end

    // ---------------- stage 4: length times trig ----------------
    logic [PROD_W-1:0]           w_prod [tlfk_pkg::LANES];
    logic [tlfk_pkg::FIELD_W-1:0] w_off_mag [tlfk_pkg::LANES];
    logic signed [OFF_W-1:0]     n4_off [tlfk_pkg::LANES];
    logic signed [OFF_W-1:0]     r4_off [tlfk_pkg::LANES];

    always_comb begin
        for (int i = 0; i < tlfk_pkg::LANES; i++) begin
            w_prod[i] = PROD_W'((i < tlfk_pkg::LANE_SIN2) ? r_first_len : r_second_len)
                      * PROD_W'(w_mag[i])
                      + (PROD_W'(1) << (TRIG_FRACTION_BITS - 1));
            w_off_mag[i] = w_prod[i][TRIG_FRACTION_BITS +: tlfk_pkg::FIELD_W];
            n4_off[i]    = r3_neg[i] ? -$signed({1'b0, w_off_mag[i]})
                                     :  $signed({1'b0, w_off_mag[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_off <= n4_off;
        end
    end

    // ---------------- stage 5: sum and clip ----------------
    logic signed [SUM_W-1:0] w_ex, w_ey, w_tx, w_ty;

    assign w_ex = SUM_W'(r_base_x) + SUM_W'(r4_off[tlfk_pkg::LANE_COS1]);
    assign w_ey = SUM_W'(r_base_y) - SUM_W'(r4_off[tlfk_pkg::LANE_SIN1]);
    assign w_tx = w_ex + SUM_W'(r4_off[tlfk_pkg::LANE_COS2]);
    assign w_ty = w_ey - SUM_W'(r4_off[tlfk_pkg::LANE_SIN2]);

    logic signed [tlfk_pkg::FIELD_W-1:0] r_elbow_x, r_elbow_y, r_tip_x, r_tip_y;
    logic                                r_saturated;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_elbow_x   <= clip16(w_ex);
            r_elbow_y   <= clip16(w_ey);
            r_tip_x     <= clip16(w_tx);
            r_tip_y     <= clip16(w_ty);
            r_saturated <= out_of_range(w_ex) || out_of_range(w_ey)
                        || out_of_range(w_tx) || out_of_range(w_ty);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_elbow_x   = r_elbow_x;
    assign o_elbow_y   = r_elbow_y;
    assign o_tip_x     = r_tip_x;
    assign o_tip_y     = r_tip_y;
    assign o_saturated = r_saturated;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r1_v && r2_v && r3_v && r4_v && r_out_v && i_out_stall))
        else $error("input stalled with a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r1_v)
        else $error("accepted word not in first stage");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && w_en5) |=> o_out_valid)
        else $error("word lost between multiply and output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r1_v && !r4_v))
        else $error("pipeline not empty after reset");

endmodule

[tb/tb_top.sv]
module tb_top;

    localparam int                FIELD_W      = tlfk_pkg::FIELD_W;
    localparam int                LEN_W        = tlfk_pkg::LEN_W;
    localparam int                CFG_INDEX_W  = tlfk_pkg::CFG_INDEX_W;
    localparam int                QUARTER_TURN = tlfk_pkg::QUARTER_TURN;
    localparam int                FULL_TURN    = tlfk_pkg::FULL_TURN;
    localparam longint unsigned   Q30_ONE      = tlfk_pkg::Q30_ONE;
    localparam longint unsigned   HALF_PI_Q30  = tlfk_pkg::HALF_PI_Q30;
    localparam int                TRIG_F       = 15;
    localparam int                TABLE_DEPTH  = 1440;
    localparam longint unsigned   HORNER_DIV [6] = '{156, 110, 72, 42, 20, 6};
    localparam int                PHASES       = 8;
    localparam int                PHASE_WORDS  = 180;
    localparam int                BUSY_PCT     = 37;
    localparam int                HOLD_CYCLES  = 80;

    typedef struct packed {
        logic signed [FIELD_W-1:0] elbow_x;
        logic signed [FIELD_W-1:0] elbow_y;
        logic signed [FIELD_W-1:0] tip_x;
        logic signed [FIELD_W-1:0] tip_y;
        logic                      saturated;
    } t_arm_pose;

    typedef enum logic {ROW_CFG, ROW_ARM} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        tlfk_pkg::t_cfg_reg        reg_sel;
        logic [FIELD_W-1:0]        value;
        logic signed [FIELD_W-1:0] a1;
        logic signed [FIELD_W-1:0] a2;
        logic                      known;
        t_arm_pose                 pose;
    } t_step_row;

    logic                      i_clk;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic signed [FIELD_W-1:0] i_first_angle  = '0;
    logic signed [FIELD_W-1:0] i_second_angle = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic signed [FIELD_W-1:0] o_elbow_x;
    logic signed [FIELD_W-1:0] o_elbow_y;
    logic signed [FIELD_W-1:0] o_tip_x;
    logic signed [FIELD_W-1:0] o_tip_y;
    logic                      o_saturated;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index    = '0;
    logic [FIELD_W-1:0]        i_cfg_data     = '0;

    longint          cfg_base_x     = 0;
    longint          cfg_base_y     = 0;
    longint unsigned cfg_first_len  = 0;
    longint unsigned cfg_second_len = 0;

    t_arm_pose pending_poses [$];
    int        tx_idle_pct     = BUSY_PCT;
    int        rx_idle_pct     = BUSY_PCT;
    int        hold_left       = 0;
    int        mismatches      = 0;
    int        words_sent      = 0;
    int        results_checked = 0;
    int        clipped_results = 0;
    int        in_stall_cycles = 0;
    int        reg_writes      = 0;

    t_step_row directed_rows [32] = '{
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd0, 16'sd0, 1'b1, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sh8000, 16'sd32767, 1'b1, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd32767, 16'sh8000, 1'b1, '0},
        '{ROW_CFG, tlfk_pkg::CFG_FIRST_LEN, 16'd16, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd0, 16'sd0, 1'b1,
          '{16'sd16, 16'sd0, 16'sd16, 16'sd0, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd1440, 16'sd0, 1'b1,
          '{16'sd0, -16'sd16, 16'sd0, -16'sd16, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd2880, 16'sd0, 1'b1,
          '{-16'sd16, 16'sd0, -16'sd16, 16'sd0, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd4320, 16'sd0, 1'b1,
          '{16'sd0, 16'sd16, 16'sd0, 16'sd16, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd5760, -16'sd5760, 1'b1,
          '{16'sd16, 16'sd0, 16'sd16, 16'sd0, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, -16'sd1440, 16'sd0, 1'b1,
          '{16'sd0, 16'sd16, 16'sd0, 16'sd16, 1'b0}},
        '{ROW_CFG, tlfk_pkg::CFG_SECOND_LEN, 16'd32, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd0, 16'sd1440, 1'b1,
          '{16'sd16, 16'sd0, 16'sd16, -16'sd32, 1'b0}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd1, 16'sd5759, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd720, 16'sd2160, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sh8000, 16'sh8000, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_BASE_X, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_BASE_Y, 16'h8000, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_FIRST_LEN, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_SECOND_LEN, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd0, 16'sd0, 1'b1,
          '{16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b1}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd1440, 16'sd1440, 1'b1,
          '{16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b1}},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd2880, 16'sd2880, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd4320, 16'sd1440, 1'b0, '0},
        // elbow clipped, tip folds back into range
        '{ROW_CFG, tlfk_pkg::CFG_BASE_X, 16'h4E20, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_BASE_Y, 16'hB1E0, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd0, 16'sd2880, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd1440, 16'sd4320, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_BASE_X, 16'h8000, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_CFG, tlfk_pkg::CFG_BASE_Y, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd2880, 16'sd4320, 1'b0, '0},
        '{ROW_ARM, tlfk_pkg::CFG_BASE_X, 16'h0000, 16'sd2879, 16'sd4321, 1'b0, '0}
    };

    two_link_forward_kinematics_top #(
        .TRIG_FRACTION_BITS (TRIG_F),
        .SINE_TABLE_DEPTH   (TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_angle  (i_first_angle),
        .i_second_angle (i_second_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_elbow_x      (o_elbow_x),
        .o_elbow_y      (o_elbow_y),
        .o_tip_x        (o_tip_x),
        .o_tip_y        (o_tip_y),
        .o_saturated    (o_saturated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // quarter-wave sine magnitude, phase 0..QUARTER_TURN, Q(TRIG_F)
    function automatic longint unsigned quarter_wave_mag(input longint unsigned p);
        longint unsigned k, x, x2, t, s, r, sub;
        if (p > 64'(QUARTER_TURN)) p = 64'(QUARTER_TURN);
        k = p * 64'(TABLE_DEPTH) / 64'(QUARTER_TURN);
        x = k * HALF_PI_Q30 / 64'(TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            sub = ((x2 * t) >> 30) / HORNER_DIV[i];
            t = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        end
        s = (x * t) >> 30;
        r = (s + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F);
        if (r > (64'd1 << TRIG_F)) r = 64'd1 << TRIG_F;
        return r;
    endfunction

    function automatic longint signed_sine(input int a);
        int              quad, q;
        longint unsigned mag;
        quad = (a / QUARTER_TURN) % 4;
        q = a % QUARTER_TURN;
        mag = (quad % 2 == 1) ? quarter_wave_mag(QUARTER_TURN - q) : quarter_wave_mag(q);
        return (quad >= 2) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic int wrap_angle(input logic signed [FIELD_W-1:0] raw);
        int r;
        r = int'(raw) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        return r;
    endfunction

    function automatic longint link_offset(input longint unsigned len, input longint trig);
        longint unsigned mag, p;
        mag = (trig < 0) ? longint'(-trig) : longint'(trig);
        p = (len * mag + (64'd1 << (TRIG_F - 1))) >> TRIG_F;
        return (trig < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [FIELD_W-1:0] clip_coord(input longint v, inout logic hit);
        if (v > 32767) begin
            v = 32767;
            hit = 1'b1;
        end
        if (v < -32768) begin
            v = -32768;
            hit = 1'b1;
        end
        return v[FIELD_W-1:0];
    endfunction

    function automatic t_arm_pose predict_pose(input logic signed [FIELD_W-1:0] a1, a2);
        int        r1, r2;
        longint    ex, ey, tx, ty;
        logic      hit;
        t_arm_pose p;
        r1 = wrap_angle(a1);
        r2 = wrap_angle(a2);
        ex = cfg_base_x + link_offset(cfg_first_len, signed_sine((r1 + QUARTER_TURN) % FULL_TURN));
        ey = cfg_base_y - link_offset(cfg_first_len, signed_sine(r1));
        tx = ex + link_offset(cfg_second_len, signed_sine((r2 + QUARTER_TURN) % FULL_TURN));
        ty = ey - link_offset(cfg_second_len, signed_sine(r2));
        hit = 1'b0;
        p.elbow_x = clip_coord(ex, hit);
        p.elbow_y = clip_coord(ey, hit);
        p.tip_x = clip_coord(tx, hit);
        p.tip_y = clip_coord(ty, hit);
        p.saturated = hit;
        return p;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_angle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 16'($urandom);
        if (sel < 85)
            return 16'((int'($urandom_range(44)) - 22) * QUARTER_TURN + int'($urandom_range(6)) - 3);
        return 16'($urandom_range(FULL_TURN - 1));
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic write_reg(input tlfk_pkg::t_cfg_reg idx, input logic [FIELD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tlfk_pkg::CFG_BASE_X:     cfg_base_x = longint'($signed(value));
            tlfk_pkg::CFG_BASE_Y:     cfg_base_y = longint'($signed(value));
            tlfk_pkg::CFG_FIRST_LEN:  cfg_first_len = value[LEN_W-1:0];
            tlfk_pkg::CFG_SECOND_LEN: cfg_second_len = value[LEN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_angles(input logic signed [FIELD_W-1:0] a1, a2, input t_arm_pose want);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_first_angle  <= a1;
        i_second_angle <= a2;
        @(posedge i_clk);
        while (o_in_stall) begin
            in_stall_cycles++;
            @(posedge i_clk);
        end
        pending_poses.push_back(want);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
    endtask

    task automatic setup_phase(input int ph);
        logic [FIELD_W-1:0] bx, by, l1, l2;
        case (ph)
            0: begin
                bx = 16'h7FFF; by = 16'h8000; l1 = 16'h7FFF; l2 = 16'h7FFF;
            end
            1: begin
                bx = 16'h8000; by = 16'h7FFF; l1 = 16'h0000; l2 = 16'h0000;
            end
            PHASES - 1: begin
                bx = 16'h8000; by = 16'h7FFF; l1 = 16'hFFFF; l2 = 16'h7FFF;
            end
            default: begin
                bx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(8191)) - 4096);
                by = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(8191)) - 4096);
                l1 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
                l2 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
            end
        endcase
        drain_results();
        write_reg(tlfk_pkg::CFG_SECOND_LEN, l2);
        write_reg(tlfk_pkg::CFG_BASE_Y, by);
        write_reg(tlfk_pkg::CFG_FIRST_LEN, l1);
        write_reg(tlfk_pkg::CFG_BASE_X, bx);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        t_arm_pose want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                results_checked++;
                if (o_saturated) clipped_results++;
                if (pending_poses.size() == 0) begin
                    flag_mismatch("result word with nothing pending");
                end else begin
                    want = pending_poses.pop_front();
                    if (o_elbow_x !== want.elbow_x)
                        flag_mismatch($sformatf("word %0d elbow_x %0d, want %0d",
                            results_checked, o_elbow_x, want.elbow_x));
                    if (o_elbow_y !== want.elbow_y)
                        flag_mismatch($sformatf("word %0d elbow_y %0d, want %0d",
                            results_checked, o_elbow_y, want.elbow_y));
                    if (o_tip_x !== want.tip_x)
                        flag_mismatch($sformatf("word %0d tip_x %0d, want %0d",
                            results_checked, o_tip_x, want.tip_x));
                    if (o_tip_y !== want.tip_y)
                        flag_mismatch($sformatf("word %0d tip_y %0d, want %0d",
                            results_checked, o_tip_y, want.tip_y));
                    if (o_saturated !== want.saturated)
                        flag_mismatch($sformatf("word %0d saturated %0b, want %0b",
                            results_checked, o_saturated, want.saturated));
                end
            end
        end
    end

    initial begin
        t_arm_pose                 want;
        logic signed [FIELD_W-1:0] a1, a2;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end else begin
                a1 = directed_rows[i].a1;
                a2 = directed_rows[i].a2;
                want = directed_rows[i].known ? directed_rows[i].pose : predict_pose(a1, a2);
                send_angles(a1, a2, want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            setup_phase(ph);
            tx_idle_pct = (ph == 2 || ph == 4) ? 0 : BUSY_PCT;
            rx_idle_pct = (ph == 2) ? 0 : BUSY_PCT;
            // back-pressure: receiver holds while the sender keeps offering
            if (ph == 4) hold_left = HOLD_CYCLES;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 4 && n == 40) tx_idle_pct = BUSY_PCT;
                a1 = pick_angle();
                a2 = pick_angle();
                send_angles(a1, a2, predict_pose(a1, a2));
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d angle words, %0d checked, %0d clipped, across %0d register writes.",
            words_sent, results_checked, clipped_results, reg_writes);
        $display("Input held off for %0d cycles under output back-pressure; %0d mismatches.",
            in_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[two_link_forward_kinematics_top.f]
hdl/tlfk_pkg.sv
hdl/tlfk_sine_rom.sv
hdl/two_link_forward_kinematics_top.sv
tb/tb_top.sv
